FILE: src/acs_pkg.sv
// Shared codes and helpers for the alarm clock setting controller.
// No dependencies; imported by acs_pair_step and alarm_clock_setting_controller.
`timescale 1ns / 1ps
`default_nettype none

package acs_pkg;

    // Event codes on the input channel
    localparam logic [2:0] OP_TICK   = 3'd0;
    localparam logic [2:0] OP_F1     = 3'd1;
    localparam logic [2:0] OP_F2     = 3'd2;
    localparam logic [2:0] OP_DOWN   = 3'd3;
    localparam logic [2:0] OP_UP     = 3'd4;
    localparam logic [2:0] OP_ACCEPT = 3'd5;
    localparam logic [2:0] OP_CANCEL = 3'd6;
    localparam logic [2:0] OP_FIRED  = 3'd7;

    // Operating modes
    localparam logic [2:0] M_UNSET  = 3'd0;
    localparam logic [2:0] M_NORMAL = 3'd1;
    localparam logic [2:0] M_MIN    = 3'd2;
    localparam logic [2:0] M_HOUR   = 3'd3;
    localparam logic [2:0] M_AMIN   = 3'd4;
    localparam logic [2:0] M_AHOUR  = 3'd5;

    // Commands to the clock core
    localparam logic [2:0] CMD_NONE      = 3'd0;
    localparam logic [2:0] CMD_ADVANCE   = 3'd1;
    localparam logic [2:0] CMD_SET_TIME  = 3'd2;
    localparam logic [2:0] CMD_SET_ALARM = 3'd3;
    localparam logic [2:0] CMD_ENABLE    = 3'd4;
    localparam logic [2:0] CMD_DISABLE   = 3'd5;
    localparam logic [2:0] CMD_SNOOZE    = 3'd6;
    localparam logic [2:0] CMD_CANCEL    = 3'd7;

    // Digit pair limits (wrap value, tens and units)
    localparam logic [3:0] MIN_LIM_TENS   = 4'd6;
    localparam logic [3:0] MIN_LIM_UNITS  = 4'd0;
    localparam logic [3:0] HOUR_LIM_TENS  = 4'd2;
    localparam logic [3:0] HOUR_LIM_UNITS = 4'd4;
    localparam logic [3:0] BCD_UNITS_MAX  = 4'd9;

    localparam logic [7:0] IDLE_TIMEOUT_RESET = 8'd60;

    // Display masks on mode entry
    typedef struct packed {
        logic [3:0] flash;
        logic [3:0] dots;
    } mode_masks_t;

    function automatic mode_masks_t mode_masks(input logic [2:0] m);
        mode_masks_t r;
        r.flash = 4'h0;
        r.dots  = 4'h0;
        unique case (m)
            M_UNSET: begin
                r.flash = 4'hF;
                r.dots  = 4'h2;
            end
            M_MIN:   r.flash = 4'hC;
            M_HOUR:  r.flash = 4'h3;
            M_AMIN: begin
                r.flash = 4'hC;
                r.dots  = 4'hF;
            end
            M_AHOUR: begin
                r.flash = 4'h3;
                r.dots  = 4'hF;
            end
            default: ;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: src/acs_pair_step.sv
// Up/down stepper for one packed BCD digit pair with a configurable wrap value.
// Depends on acs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module acs_pair_step
    import acs_pkg::*;
(
    input  wire logic [7:0] pair_in,
    input  wire logic       up,
    input  wire logic [3:0] lim_tens,
    input  wire logic [3:0] lim_units,
    output logic      [7:0] pair_out
);

    logic [3:0] tens;
    logic [3:0] units;
    logic [4:0] units_inc;
    logic [3:0] up_tens;
    logic [3:0] up_units;
    logic [3:0] dn_tens;
    logic [3:0] dn_units;

    assign tens      = pair_in[7:4];
    assign units     = pair_in[3:0];
    assign units_inc = {1'b0, units} + 5'd1;

    // Count up: units roll into tens, whole pair wraps at the limit
    always_comb begin
        up_tens  = tens;
        up_units = units_inc[3:0];
        if (units_inc > {1'b0, BCD_UNITS_MAX}) begin
            up_tens  = tens + 4'd1;
            up_units = 4'd0;
        end
        if (up_units == lim_units && up_tens == lim_tens) begin
            up_tens  = 4'd0;
            up_units = 4'd0;
        end
    end

    // Count down: zero wraps to one below the limit
    always_comb begin
        if (tens == 4'd0 && units == 4'd0) begin
            if (lim_units != 4'd0) begin
                dn_tens  = lim_tens;
                dn_units = lim_units - 4'd1;
            end else begin
                dn_tens  = lim_tens - 4'd1;
                dn_units = BCD_UNITS_MAX;
            end
        end else if (units == 4'd0) begin
            dn_tens  = tens - 4'd1;
            dn_units = BCD_UNITS_MAX;
        end else begin
            dn_tens  = tens;
            dn_units = units - 4'd1;
        end
    end

    assign pair_out = up ? {up_tens, up_units} : {dn_tens, dn_units};

endmodule

`default_nettype wire

FILE: src/alarm_clock_setting_controller.sv
// Alarm clock setting controller: event register, mode/digit update logic,
// result register. Depends on acs_pkg and acs_pair_step.
//
// Each item is one event (half-second tick, key, or alarm fired) and yields
// exactly one result item: mode, shown digits, flash/dot masks, buzzer, alarm
// enable and one clock core command. An item passes through an input register
// and a result register. One item per cycle is sustained since the whole
// update is a single pass over a handful of state registers; a stalled result
// holds both registers. idle_timeout is written through cfg_we/cfg_wdata; the
// user must write it only while no item is in flight, as the block does not
// enforce this.
`timescale 1ns / 1ps
`default_nettype none

module alarm_clock_setting_controller
    import acs_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration
    input  wire logic        cfg_we,
    input  wire logic [7:0]  cfg_wdata,
    // event channel
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [2:0]  s_op,
    input  wire logic [15:0] s_clock_time,
    // result channel
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [2:0]       m_mode,
    output logic [15:0]      m_display_digits,
    output logic [3:0]       m_flash_mask,
    output logic [3:0]       m_dot_mask,
    output logic [2:0]       m_clock_cmd,
    output logic [15:0]      m_cmd_time,
    output logic             m_buzzer_on,
    output logic             m_alarm_enabled
);

    // Configuration register
    logic [7:0] idle_timeout_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idle_timeout_reg <= IDLE_TIMEOUT_RESET;
        end else if (cfg_we) begin
            idle_timeout_reg <= cfg_wdata;
        end
    end

    // Input register stage
    logic        in_valid_reg;
    logic [2:0]  op_reg;
    logic [15:0] ct_reg;
    logic        advance;
    logic        out_valid_reg;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            op_reg <= s_op;
            ct_reg <= s_clock_time;
        end
    end

    // Controller state
    logic [2:0]  mode_reg,      mode_next;
    logic [15:0] time_reg,      time_next;
    logic [15:0] alarm_reg,     alarm_next;
    logic        alarm_on_reg,  alarm_on_next;
    logic        alarm_set_reg, alarm_set_next;
    logic        ringing_reg,   ringing_next;
    logic        buzzer_reg,    buzzer_next;
    logic        half_reg,      half_next;
    logic        sdot_reg,      sdot_next;
    logic [7:0]  idle_reg,      idle_next;
    logic [3:0]  flash_reg,     flash_next;
    logic [3:0]  dot_reg,       dot_next;
    logic [2:0]  cmd_next;
    logic [15:0] ctime_next;

    // Digit steppers on the pair being edited
    logic        edit_alarm;
    logic [15:0] edit_src;
    logic [7:0]  min_stepped;
    logic [7:0]  hour_stepped;
    logic        step_up;

    assign edit_alarm = (mode_reg == M_AMIN) || (mode_reg == M_AHOUR);
    assign edit_src   = edit_alarm ? alarm_reg : time_reg;
    assign step_up    = (op_reg == OP_UP);

    acs_pair_step u_min_step (
        .pair_in   (edit_src[7:0]),
        .up        (step_up),
        .lim_tens  (MIN_LIM_TENS),
        .lim_units (MIN_LIM_UNITS),
        .pair_out  (min_stepped)
    );

    acs_pair_step u_hour_step (
        .pair_in   (edit_src[15:8]),
        .up        (step_up),
        .lim_tens  (HOUR_LIM_TENS),
        .lim_units (HOUR_LIM_UNITS),
        .pair_out  (hour_stepped)
    );

    // Per-item update
    logic [7:0]  idle_inc;
    logic        is_step;
    mode_masks_t masks;

    assign idle_inc = idle_reg + 8'd1;
    assign is_step  = (op_reg == OP_UP) || (op_reg == OP_DOWN);

    always_comb begin
        mode_next      = mode_reg;
        time_next      = time_reg;
        alarm_next     = alarm_reg;
        alarm_on_next  = alarm_on_reg;
        alarm_set_next = alarm_set_reg;
        ringing_next   = ringing_reg;
        buzzer_next    = buzzer_reg;
        half_next      = half_reg;
        sdot_next      = sdot_reg;
        idle_next      = idle_reg;
        flash_next     = flash_reg;
        dot_next       = dot_reg;
        cmd_next       = CMD_NONE;
        ctime_next     = 16'h0000;
        masks          = mode_masks(M_NORMAL);

        if (op_reg == OP_TICK) begin
            half_next = !half_reg;
            if (mode_reg != M_UNSET && half_next) begin
                cmd_next = CMD_ADVANCE;
            end
            if (ringing_reg) begin
                buzzer_next = !buzzer_reg;
            end
            // idle timeout in the edit modes
            if (mode_reg != M_NORMAL && mode_reg != M_UNSET) begin
                idle_next = idle_inc;
                if (idle_inc >= idle_timeout_reg) begin
                    mode_next  = M_NORMAL;
                    flash_next = masks.flash;
                    dot_next   = masks.dots;
                    idle_next  = 8'd0;
                end
            end
            // normal mode: follow the clock core, blink the seconds dot
            if (mode_next == M_NORMAL) begin
                if (half_next) begin
                    time_next = ct_reg;
                end
                sdot_next = !sdot_reg;
                dot_next  = {alarm_on_reg, dot_next[2], sdot_next, dot_next[0]};
            end
        end else if (op_reg == OP_FIRED) begin
            ringing_next = 1'b1;
        end else begin
            idle_next = 8'd0;
            if (ringing_reg) begin
                if (op_reg == OP_ACCEPT || op_reg == OP_CANCEL) begin
                    cmd_next     = (op_reg == OP_ACCEPT) ? CMD_SNOOZE : CMD_CANCEL;
                    ringing_next = 1'b0;
                    buzzer_next  = 1'b0;
                end
            end else begin
                unique case (mode_reg)
                    M_UNSET: begin
                        if (op_reg == OP_F1) mode_next = M_MIN;
                    end
                    M_NORMAL: begin
                        if (op_reg == OP_F1) begin
                            mode_next = M_MIN;
                        end else if (op_reg == OP_F2) begin
                            mode_next = M_AMIN;
                        end else if (op_reg == OP_ACCEPT) begin
                            if (alarm_set_reg) begin
                                cmd_next      = CMD_ENABLE;
                                alarm_on_next = 1'b1;
                            end
                        end else if (op_reg == OP_CANCEL) begin
                            cmd_next      = CMD_DISABLE;
                            alarm_on_next = 1'b0;
                        end
                    end
                    M_MIN: begin
                        if (op_reg == OP_ACCEPT) begin
                            mode_next = M_HOUR;
                        end else if (is_step) begin
                            time_next = {time_reg[15:8], min_stepped};
                        end else if (op_reg == OP_CANCEL) begin
                            mode_next = M_NORMAL;
                        end
                    end
                    M_HOUR: begin
                        if (is_step) begin
                            time_next = {hour_stepped, time_reg[7:0]};
                        end else if (op_reg == OP_ACCEPT) begin
                            cmd_next   = CMD_SET_TIME;
                            ctime_next = time_reg;
                            mode_next  = M_NORMAL;
                        end else if (op_reg == OP_CANCEL) begin
                            mode_next = M_NORMAL;
                        end
                    end
                    M_AMIN: begin
                        if (op_reg == OP_ACCEPT) begin
                            mode_next = M_AHOUR;
                        end else if (is_step) begin
                            alarm_next = {alarm_reg[15:8], min_stepped};
                        end else if (op_reg == OP_CANCEL) begin
                            mode_next = M_NORMAL;
                        end
                    end
                    M_AHOUR: begin
                        if (is_step) begin
                            alarm_next = {hour_stepped, alarm_reg[7:0]};
                        end else if (op_reg == OP_ACCEPT) begin
                            cmd_next       = CMD_SET_ALARM;
                            ctime_next     = alarm_reg;
                            alarm_set_next = 1'b1;
                            alarm_on_next  = 1'b1;
                            mode_next      = M_NORMAL;
                        end else if (op_reg == OP_CANCEL) begin
                            mode_next = M_NORMAL;
                        end
                    end
                    default: ;
                endcase
                // mode entry reloads the masks
                if (mode_next != mode_reg ||
                    (mode_reg == M_HOUR && op_reg == OP_ACCEPT) ||
                    (mode_reg == M_AHOUR && op_reg == OP_ACCEPT)) begin
                    masks      = mode_masks(mode_next);
                    flash_next = masks.flash;
                    dot_next   = masks.dots;
                end
                if (mode_next == M_NORMAL) begin
                    dot_next = {alarm_on_next, dot_next[2:0]};
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= M_UNSET;
            time_reg      <= 16'h0000;
            alarm_reg     <= 16'h0000;
            alarm_on_reg  <= 1'b0;
            alarm_set_reg <= 1'b0;
            ringing_reg   <= 1'b0;
            buzzer_reg    <= 1'b0;
            half_reg      <= 1'b0;
            sdot_reg      <= 1'b0;
            idle_reg      <= 8'd0;
            flash_reg     <= 4'hF;
            dot_reg       <= 4'h2;
        end else if (advance) begin
            mode_reg      <= mode_next;
            time_reg      <= time_next;
            alarm_reg     <= alarm_next;
            alarm_on_reg  <= alarm_on_next;
            alarm_set_reg <= alarm_set_next;
            ringing_reg   <= ringing_next;
            buzzer_reg    <= buzzer_next;
            half_reg      <= half_next;
            sdot_reg      <= sdot_next;
            idle_reg      <= idle_next;
            flash_reg     <= flash_next;
            dot_reg       <= dot_next;
        end
    end

    // Result register
    logic        alarm_view;
    logic [2:0]  r_mode_reg;
    logic [15:0] r_digits_reg;
    logic [3:0]  r_flash_reg;
    logic [3:0]  r_dot_reg;
    logic [2:0]  r_cmd_reg;
    logic [15:0] r_ctime_reg;
    logic        r_buzzer_reg;
    logic        r_alarm_en_reg;

    assign alarm_view = (mode_next == M_AMIN) || (mode_next == M_AHOUR);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            r_mode_reg     <= mode_next;
            r_digits_reg   <= alarm_view ? alarm_next : time_next;
            r_flash_reg    <= flash_next;
            r_dot_reg      <= dot_next;
            r_cmd_reg      <= cmd_next;
            r_ctime_reg    <= ctime_next;
            r_buzzer_reg   <= buzzer_next;
            r_alarm_en_reg <= alarm_on_next;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_mode           = r_mode_reg;
    assign m_display_digits = r_digits_reg;
    assign m_flash_mask     = r_flash_reg;
    assign m_dot_mask       = r_dot_reg;
    assign m_clock_cmd      = r_cmd_reg;
    assign m_cmd_time       = r_ctime_reg;
    assign m_buzzer_on      = r_buzzer_reg;
    assign m_alarm_enabled  = r_alarm_en_reg;

    // Checks on the controller state
    a_buzzer_needs_ring: assert property (@(posedge aclk) disable iff (!aresetn)
        !ringing_reg |-> !buzzer_reg)
        else $error("buzzer active while alarm not ringing");

    a_enable_needs_set: assert property (@(posedge aclk) disable iff (!aresetn)
        alarm_on_reg |-> alarm_set_reg)
        else $error("alarm enabled before any alarm time was set");

    a_normal_no_flash: assert property (@(posedge aclk) disable iff (!aresetn)
        mode_reg == M_NORMAL |-> flash_reg == 4'h0)
        else $error("digits flashing in normal mode");

    a_set_cmd_normal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_clock_cmd == CMD_SET_TIME || m_clock_cmd == CMD_SET_ALARM)
        |-> m_mode == M_NORMAL)
        else $error("set command issued without return to normal mode");

    a_stage_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg && $stable(op_reg) && $stable(ct_reg))
        else $error("stalled event lost from input register");

endmodule

`default_nettype wire
